@@ rtl/group_barrier_table_defines.svh @@
// group_barrier_table_defines.svh: assertion macros for the barrier table.
// Used by group_barrier_table.sv; depends on nothing.
`ifndef GROUP_BARRIER_TABLE_DEFINES_SVH
`define GROUP_BARRIER_TABLE_DEFINES_SVH
// implication checked every clock, quiet during reset
`define GBT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define GBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/gbt_pkg.sv @@
// gbt_pkg: word types and status codes of the barrier table.
// Used by group_barrier_table; depends on nothing.
`default_nettype none
package gbt_pkg;
   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0, KIND_JOIN = 2'd1, KIND_RELEASE = 2'd2, KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_REACHED = 3'd1, ST_NOGROUP = 3'd2, ST_DUP = 3'd3,
      ST_INVALID = 3'd4, ST_EXISTS = 3'd5, ST_FULL = 3'd6, ST_MFULL = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] group_id;
      logic [7:0]  count;
      logic [21:0] member_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        member_valid;
      logic [21:0] released_id;
      logic [7:0]  remaining;
      logic [5:0]  blocked;
      logic [8:0]  total;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/group_barrier_table.sv @@
// Barrier group table. A command word (create, join, release, query) is
// taken when start is high and busy is low; busy then stays high until the
// last result word appears; it is low while that word is shown. Each result
// is on rsp_ for one cycle, marked by rsp_valid, and cannot be held off, with
// rsp_word.last on the final word of a command. Group key, count and blocked
// fields live in flip-flops per slot; member ids live in one RAM of
// MAX_GROUPS*MAX_MEMBERS words with registered read data. A command runs a
// slot search over all MAX_GROUPS slots (one slot a cycle); create and query
// then answer from the search, join reads back each blocked member from the
// RAM to check for a duplicate, and release emits one member word a cycle.
`default_nettype none
module group_barrier_table #(
   parameter int MAX_GROUPS  = 16,
   parameter int MAX_MEMBERS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire gbt_pkg::req_type req_word,
   output logic                 rsp_valid,
   output gbt_pkg::rsp_type     rsp_word
);
   import gbt_pkg::*;
   `include "group_barrier_table_defines.svh"

   localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CW = $clog2(MAX_MEMBERS + 1);
   localparam int SW = $clog2(MAX_GROUPS + 1);
   localparam int AW = $clog2(MAX_GROUPS * MAX_MEMBERS);
   localparam int DEPTH = MAX_GROUPS * MAX_MEMBERS;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_JREAD, S_JCHECK, S_REL
   } state_type;

   // per-slot control state
   logic [MAX_GROUPS-1:0] used_ff;
   logic [15:0]           key_ff [MAX_GROUPS];
   logic [7:0]            rem_ff [MAX_GROUPS];
   logic [CW-1:0]         blk_ff [MAX_GROUPS];

   state_type     state_ff;
   req_type       req_ff;
   logic [SW-1:0] scan_ff;      // slot being searched
   logic          found_ff;
   logic [GW-1:0] hit_ff;
   logic          free_ok_ff;
   logic [GW-1:0] free_ff;
   logic [CW-1:0] idx_ff;       // member index within a group
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [GW-1:0] scan_idx;
   assign scan_idx = scan_ff[GW-1:0];

   // member RAM
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [21:0]   ram_rdata;
   logic [AW:0]   hit_base;

   assign hit_base = ((AW+1)'(hit_ff) * (AW+1)'(MAX_MEMBERS));
   assign ram_raddr = AW'(hit_base + (AW+1)'(idx_ff[MW-1:0]));
   assign ram_waddr = AW'(hit_base + (AW+1)'(blk_ff[hit_ff]));
   assign ram_we = (state_ff == S_JCHECK) && (idx_ff >= blk_ff[hit_ff])
                   && (blk_ff[hit_ff] < CW'(MAX_MEMBERS));

   gbt_ram #(.WIDTH(22), .DEPTH(DEPTH)) u_members (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ff.member_id),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   function automatic rsp_type mk(input logic [2:0] st, input logic v,
                                  input logic [21:0] id, input logic [7:0] r,
                                  input logic [CW-1:0] b, input logic l);
      rsp_type o;
      o.status = st; o.member_valid = v; o.released_id = id; o.remaining = r;
      o.blocked = 6'(b); o.total = 9'(r) + 9'(b); o.last = l;
      return o;
   endfunction

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // command sequencer
   always_ff @(posedge clock) begin
      logic rsp_fire;
      rsp_fire = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         for (int g = 0; g < MAX_GROUPS; g++) blk_ff[g] <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_word;
                  scan_ff <= '0;
                  found_ff <= 1'b0;
                  free_ok_ff <= 1'b0;
                  hit_ff <= '0;
                  free_ff <= '0;
                  idx_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (used_ff[scan_idx] && key_ff[scan_idx] == req_ff.group_id
                   && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_ff <= scan_idx;
               end
               if (!used_ff[scan_idx] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_ff <= scan_idx;
               end
               scan_ff <= scan_ff + SW'(1);
               if (scan_ff == SW'(MAX_GROUPS - 1)) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (req_ff.kind == KIND_CREATE) begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  if (req_ff.group_id == '0 || req_ff.count == '0)
                     rsp_ff <= mk(ST_INVALID, 1'b0, '0, '0, '0, 1'b1);
                  else if (found_ff)
                     rsp_ff <= mk(ST_EXISTS, 1'b0, '0, '0, '0, 1'b1);
                  else if (!free_ok_ff)
                     rsp_ff <= mk(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                  else begin
                     used_ff[free_ff] <= 1'b1;
                     key_ff[free_ff] <= req_ff.group_id;
                     rem_ff[free_ff] <= req_ff.count;
                     blk_ff[free_ff] <= '0;
                     rsp_ff <= mk(ST_OK, 1'b0, '0, req_ff.count, '0, 1'b1);
                  end
               end else if ((req_ff.kind == KIND_JOIN && req_ff.group_id == '0)) begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  rsp_ff <= mk(ST_INVALID, 1'b0, '0, '0, '0, 1'b1);
               end else if (!found_ff) begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  rsp_ff <= mk(ST_NOGROUP, 1'b0, '0, '0, '0, 1'b1);
               end else if (req_ff.kind == KIND_QUERY) begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  rsp_ff <= mk(ST_OK, 1'b0, '0, rem_ff[hit_ff], blk_ff[hit_ff], 1'b1);
               end else if (req_ff.kind == KIND_JOIN) begin
                  state_ff <= S_JREAD;
               end else if (blk_ff[hit_ff] == '0) begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  used_ff[hit_ff] <= 1'b0;
                  rsp_ff <= mk(ST_OK, 1'b0, '0, rem_ff[hit_ff], '0, 1'b1);
               end else begin
                  state_ff <= S_REL;
               end
            end
            // join: read address idx issued; next cycle compare
            S_JREAD: begin
               state_ff <= S_JCHECK;
            end
            S_JCHECK: begin
               if (idx_ff < blk_ff[hit_ff]) begin
                  if (ram_rdata == req_ff.member_id) begin
                     rsp_fire = 1'b1;
                     rsp_ff <= mk(ST_DUP, 1'b0, '0, rem_ff[hit_ff],
                                  blk_ff[hit_ff], 1'b1);
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff + CW'(1);
                     state_ff <= S_JREAD;
                  end
               end else begin
                  rsp_fire = 1'b1;
                  state_ff <= S_IDLE;
                  if (blk_ff[hit_ff] >= CW'(MAX_MEMBERS))
                     rsp_ff <= mk(ST_MFULL, 1'b0, '0, rem_ff[hit_ff],
                                  blk_ff[hit_ff], 1'b1);
                  else begin
                     blk_ff[hit_ff] <= blk_ff[hit_ff] + CW'(1);
                     if (rem_ff[hit_ff] != '0)
                        rem_ff[hit_ff] <= rem_ff[hit_ff] - 8'd1;
                     rsp_ff <= mk((rem_ff[hit_ff] <= 8'd1) ? ST_REACHED : ST_OK,
                                  1'b0, '0,
                                  (rem_ff[hit_ff] != '0) ? rem_ff[hit_ff] - 8'd1 : 8'd0,
                                  blk_ff[hit_ff] + CW'(1), 1'b1);
                  end
               end
            end
            // release: data for the address issued last cycle (idx - 1) arrives now
            S_REL: begin
               if (idx_ff != '0) begin
                  rsp_fire = 1'b1;
                  rsp_ff <= mk(ST_OK, 1'b1, ram_rdata, rem_ff[hit_ff],
                               blk_ff[hit_ff], idx_ff == blk_ff[hit_ff]);
               end
               if (idx_ff == blk_ff[hit_ff]) begin
                  used_ff[hit_ff] <= 1'b0;
                  blk_ff[hit_ff] <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      rsp_valid_ff <= rsp_fire;
   end

   // checks
   `GBT_ASSERT_IMPL(a_no_rsp_idle_start, clock, reset,
      rsp_valid && rsp_word.member_valid, rsp_word.status == ST_OK,
      "released member word with non-ok status")
   `GBT_ASSERT_NEXT(a_last_frees, clock, reset,
      rsp_valid && rsp_word.last, !rsp_valid,
      "result word right after the last word of a command")
   `GBT_ASSERT_IMPL(a_busy_on_start, clock, reset,
      state_ff == S_SCAN, busy,
      "busy low while searching")
endmodule
`default_nettype wire

@@ rtl/gbt_ram.sv @@
// gbt_ram: generic single-write, single-read RAM with registered read data.
// Used by group_barrier_table; depends on nothing.
`default_nettype none
module gbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
